// ----- rtl/core/tile_column_rectangle_merger_defines.svh -----
// Assertion macros shared by the tile column rectangle merger RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TILE_COLUMN_RECTANGLE_MERGER_DEFINES_SVH
`define TILE_COLUMN_RECTANGLE_MERGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCRM_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tcrm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCRM_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tcrm: next-cycle check failed");

`endif

// ----- rtl/core/tcrm_pkg.sv -----
// Shared constants and types of the tile column rectangle merger.
// No dependencies; tcrm_if, tcrm_lane and the merger use this package.
`default_nettype none

package tcrm_pkg;

    localparam int ROWS_DEFAULT = 32;
    localparam int COORD_W      = 16;
    localparam int OCC_W        = 32;

    typedef struct packed {
        logic                      upd;
        logic signed [COORD_W-1:0] column_x;
    } lane_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/tcrm_if.sv -----
// Handshake channels of the tile column rectangle merger: columns in,
// rectangles out, and the row base register write. Depends on tcrm_pkg.
`default_nettype none

interface tcrm_column_if;
    logic                               valid;
    logic                               ready;
    logic signed [tcrm_pkg::COORD_W-1:0] column_x;
    logic        [tcrm_pkg::OCC_W-1:0]   occupancy;
    logic                               last_column;

    modport source (output valid, output column_x, output occupancy, output last_column,
                    input ready);
    modport sink   (input valid, input column_x, input occupancy, input last_column,
                    output ready);
endinterface

interface tcrm_rect_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tcrm_pkg::COORD_W-1:0]  rect_min_x;
    logic signed [tcrm_pkg::COORD_W:0]    rect_max_x;
    logic signed [tcrm_pkg::COORD_W-1:0]  rect_min_y;
    logic signed [tcrm_pkg::COORD_W:0]    rect_max_y;
    logic                                 last_of_run;

    modport source (output valid, output rect_min_x, output rect_max_x, output rect_min_y,
                    output rect_max_y, output last_of_run, input ready);
    modport sink   (input valid, input rect_min_x, input rect_max_x, input rect_min_y,
                    input rect_max_y, input last_of_run, output ready);
endinterface

interface tcrm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic signed [tcrm_pkg::COORD_W-1:0] row_base;

    modport source (output valid, output row_base, input ready);
    modport sink   (input valid, input row_base, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tcrm_lane.sv -----
// One row lane: holds the left x of the rectangle whose run starts at this row
// and rewrites it when a new run starts here. Depends on tcrm_pkg.
`default_nettype none

module tcrm_lane (
    input  wire logic                                clk,
    input  wire tcrm_pkg::lane_ctl_t                 ctl,
    input  wire logic                                cur_bit,
    input  wire logic                                cur_below,
    input  wire logic                                matched_bit,
    output logic signed [tcrm_pkg::COORD_W-1:0]      start_x
);

    logic signed [tcrm_pkg::COORD_W-1:0] start_x_reg;
    logic signed [tcrm_pkg::COORD_W-1:0] start_x_next;
    logic                                new_start;

    // A run starts here when the row is set and the row below is clear; it
    // keeps its old left edge only when it continues a matching run.
    assign new_start = cur_bit && !cur_below && !matched_bit;

    always_comb
    begin
        start_x_next = start_x_reg;
        if (ctl.upd && new_start)
        begin
            start_x_next = ctl.column_x;
        end
    end

    always_ff @(posedge clk)
    begin
        start_x_reg <= start_x_next;
    end

    assign start_x = start_x_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tcrm_run_pick.sv -----
// Picks the lowest run of set bits out of a row mask, encodes its bounds and
// checks whether the current column holds exactly the same run. No dependencies.
`default_nettype none

module tcrm_run_pick #(
    parameter int ROWS = 32
) (
    input  wire logic [ROWS-1:0]              rem,
    input  wire logic [ROWS-1:0]              cur,
    output logic      [ROWS-1:0]              block,
    output logic      [$clog2(ROWS)-1:0]      run_lo,
    output logic      [$clog2(ROWS+1)-1:0]    run_end,
    output logic                              exact
);

    localparam int IDX_W = $clog2(ROWS);
    localparam int END_W = $clog2(ROWS + 1);

    logic [ROWS-1:0]  fill;
    logic [ROWS-1:0]  carry;
    logic [ROWS-1:0]  window;
    logic [IDX_W-1:0] run_hi;

    // Filling the trailing zeros and adding one clears exactly the lowest run.
    assign fill   = rem | (rem - ROWS'(1));
    assign carry  = fill + ROWS'(1);
    assign block  = rem & ~carry;

    // The run plus one row on each side must read the same in the current column.
    assign window = block | (block << 1) | (block >> 1);
    assign exact  = ((cur & window) == block);

    always_comb
    begin
        run_lo = '0;
        run_hi = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (block[i])
            begin
                run_lo = IDX_W'(i);
            end
        end
        for (int j = 0; j < ROWS; j++)
        begin
            if (block[j])
            begin
                run_hi = IDX_W'(j);
            end
        end
    end

    assign run_end = END_W'(run_hi) + END_W'(1);

endmodule

`default_nettype wire

// ----- rtl/core/tile_column_rectangle_merger.sv -----
// Tile column rectangle merger: takes occupancy columns left to right and
// emits the merged rectangles. An accepted column is loaded, then each open
// run of the previous column is extracted, then the row lanes are updated and
// the final beat is released. The last column also has each of its own runs
// extracted after the lane update, in a pass that closes before the release.
// The run extractor handles one run per cycle, and stalls on the rectangle
// channel can hold it. The row base register is written on its own channel,
// which is always ready; the user must write it only between columns, and the
// block itself does not enforce this.
// Depends on tcrm_pkg, tcrm_if, tcrm_lane, tcrm_run_pick and the defines header.
`default_nettype none

`include "tile_column_rectangle_merger_defines.svh"

module tile_column_rectangle_merger #(
    parameter int ROWS = tcrm_pkg::ROWS_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tcrm_column_if.sink   column,
    tcrm_rect_if.source   rect,
    tcrm_cfg_if.sink      cfg
);

    localparam int CW    = tcrm_pkg::COORD_W;
    localparam int IDX_W = $clog2(ROWS);
    localparam int END_W = $clog2(ROWS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PREV  = 2'd1;
    localparam logic [1:0] S_CUR   = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic signed [CW-1:0]   row_base_reg, row_base_next;
    logic [ROWS-1:0]        prev_runs_reg, prev_runs_next;
    logic signed [CW-1:0]   prev_x_reg, prev_x_next;
    logic                   have_prev_reg, have_prev_next;
    logic [ROWS-1:0]        rem_reg, rem_next;
    logic [ROWS-1:0]        matched_reg, matched_next;
    logic                   adj_reg, adj_next;
    logic                   last_reg, last_next;
    logic signed [CW-1:0]   x_reg, x_next;
    logic [ROWS-1:0]        cur_reg, cur_next;
    logic                   held_valid_reg, held_valid_next;
    logic                   out_valid_reg, out_valid_next;

    logic signed [CW-1:0]   held_min_x_reg, held_min_x_next;
    logic signed [CW:0]     held_max_x_reg, held_max_x_next;
    logic [CW-1:0]          held_min_y_reg, held_min_y_next;
    logic signed [CW:0]     held_max_y_reg, held_max_y_next;
    logic signed [CW-1:0]   out_min_x_reg, out_min_x_next;
    logic signed [CW:0]     out_max_x_reg, out_max_x_next;
    logic [CW-1:0]          out_min_y_reg, out_min_y_next;
    logic signed [CW:0]     out_max_y_reg, out_max_y_next;
    logic                   out_last_reg, out_last_next;

    logic [ROWS-1:0]        block;
    logic [IDX_W-1:0]       run_lo;
    logic [END_W-1:0]       run_end;
    logic                   exact;
    logic signed [CW-1:0]   start_x [ROWS];
    tcrm_pkg::lane_ctl_t    lane_ctl;

    logic                   in_phase;
    logic                   has_run;
    logic                   matched_now;
    logic                   emit_req;
    logic                   out_free;
    logic                   emit_go;
    logic                   step_go;
    logic                   push_last;
    logic signed [CW-1:0]   new_min_x;
    logic signed [CW:0]     new_max_x;
    logic [CW-1:0]          new_min_y;
    logic signed [CW:0]     new_max_y;

    tcrm_run_pick #(
        .ROWS (ROWS)
    ) u_pick (
        .rem     (rem_reg),
        .cur     (cur_reg),
        .block   (block),
        .run_lo  (run_lo),
        .run_end (run_end),
        .exact   (exact)
    );

    assign lane_ctl.upd      = (state_reg == S_PREV) && (rem_reg == '0);
    assign lane_ctl.column_x = x_reg;

    for (genvar r = 0; r < ROWS; r++)
    begin : g_lane
        logic below;
        if (r == 0)
        begin : g_bottom
            assign below = 1'b0;
        end
        else
        begin : g_upper
            assign below = cur_reg[r-1];
        end

        tcrm_lane u_lane (
            .clk         (clk),
            .ctl         (lane_ctl),
            .cur_bit     (cur_reg[r]),
            .cur_below   (below),
            .matched_bit (matched_reg[r]),
            .start_x     (start_x[r])
        );
    end

    assign in_phase    = (state_reg == S_PREV) || (state_reg == S_CUR);
    assign has_run     = in_phase && (rem_reg != '0);
    assign matched_now = (state_reg == S_PREV) && adj_reg && exact;
    assign emit_req    = has_run && !matched_now;
    assign out_free    = !out_valid_reg || rect.ready;
    assign emit_go     = emit_req && (!held_valid_reg || out_free);
    assign step_go     = has_run && (matched_now || emit_go);
    assign push_last   = (state_reg == S_FLUSH) && held_valid_reg && out_free;

    assign new_min_x = start_x[run_lo];
    assign new_max_x = (state_reg == S_PREV) ? ({prev_x_reg[CW-1], prev_x_reg} + (CW+1)'(1))
                                             : ({x_reg[CW-1], x_reg} + (CW+1)'(1));
    assign new_min_y = CW'(row_base_reg) + CW'(run_lo);
    assign new_max_y = {row_base_reg[CW-1], row_base_reg} + (CW+1)'(run_end);

    always_comb
    begin
        state_next      = state_reg;
        row_base_next   = row_base_reg;
        prev_runs_next  = prev_runs_reg;
        prev_x_next     = prev_x_reg;
        have_prev_next  = have_prev_reg;
        rem_next        = rem_reg;
        matched_next    = matched_reg;
        adj_next        = adj_reg;
        last_next       = last_reg;
        x_next          = x_reg;
        cur_next        = cur_reg;
        held_valid_next = held_valid_reg;
        out_valid_next  = out_valid_reg;
        held_min_x_next = held_min_x_reg;
        held_max_x_next = held_max_x_reg;
        held_min_y_next = held_min_y_reg;
        held_max_y_next = held_max_y_reg;
        out_min_x_next  = out_min_x_reg;
        out_max_x_next  = out_max_x_reg;
        out_min_y_next  = out_min_y_reg;
        out_max_y_next  = out_max_y_reg;
        out_last_next   = out_last_reg;

        if (cfg.valid)
        begin
            row_base_next = cfg.row_base;
        end

        if (rect.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (column.valid)
                begin
                    x_next       = column.column_x;
                    cur_next     = ROWS'(column.occupancy);
                    last_next    = column.last_column;
                    rem_next     = have_prev_reg ? prev_runs_reg : '0;
                    adj_next     = have_prev_reg &&
                                   ({column.column_x[CW-1], column.column_x} ==
                                    ({prev_x_reg[CW-1], prev_x_reg} + (CW+1)'(1)));
                    matched_next = '0;
                    state_next   = S_PREV;
                end
            end
            S_PREV, S_CUR:
            begin
                if (rem_reg == '0)
                begin
                    if ((state_reg == S_PREV) && last_reg)
                    begin
                        rem_next   = cur_reg;
                        state_next = S_CUR;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
                else if (step_go)
                begin
                    rem_next = rem_reg & ~block;
                    if (matched_now)
                    begin
                        matched_next = matched_reg | (block & ~(block << 1));
                    end
                end
            end
            S_FLUSH:
            begin
                if (!held_valid_reg || out_free)
                begin
                    state_next = S_IDLE;
                    if (last_reg)
                    begin
                        prev_runs_next = '0;
                        have_prev_next = 1'b0;
                    end
                    else
                    begin
                        prev_runs_next = cur_reg;
                        prev_x_next    = x_reg;
                        have_prev_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The newest rectangle waits in the held stage until it is known
        // whether another one follows it for the same column.
        if (emit_go)
        begin
            if (held_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_min_x_next = held_min_x_reg;
                out_max_x_next = held_max_x_reg;
                out_min_y_next = held_min_y_reg;
                out_max_y_next = held_max_y_reg;
                out_last_next  = 1'b0;
            end
            held_valid_next = 1'b1;
            held_min_x_next = new_min_x;
            held_max_x_next = new_max_x;
            held_min_y_next = new_min_y;
            held_max_y_next = new_max_y;
        end

        if (push_last)
        begin
            out_valid_next  = 1'b1;
            out_min_x_next  = held_min_x_reg;
            out_max_x_next  = held_max_x_reg;
            out_min_y_next  = held_min_y_reg;
            out_max_y_next  = held_max_y_reg;
            out_last_next   = 1'b1;
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            row_base_reg   <= '0;
            prev_runs_reg  <= '0;
            prev_x_reg     <= '0;
            have_prev_reg  <= 1'b0;
            rem_reg        <= '0;
            matched_reg    <= '0;
            adj_reg        <= 1'b0;
            last_reg       <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_base_reg   <= row_base_next;
            prev_runs_reg  <= prev_runs_next;
            prev_x_reg     <= prev_x_next;
            have_prev_reg  <= have_prev_next;
            rem_reg        <= rem_next;
            matched_reg    <= matched_next;
            adj_reg        <= adj_next;
            last_reg       <= last_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        cur_reg        <= cur_next;
        held_min_x_reg <= held_min_x_next;
        held_max_x_reg <= held_max_x_next;
        held_min_y_reg <= held_min_y_next;
        held_max_y_reg <= held_max_y_next;
        out_min_x_reg  <= out_min_x_next;
        out_max_x_reg  <= out_max_x_next;
        out_min_y_reg  <= out_min_y_next;
        out_max_y_reg  <= out_max_y_next;
        out_last_reg   <= out_last_next;
    end

    assign column.ready     = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign rect.valid       = out_valid_reg;
    assign rect.rect_min_x  = out_min_x_reg;
    assign rect.rect_max_x  = out_max_x_reg;
    assign rect.rect_min_y  = out_min_y_reg;
    assign rect.rect_max_y  = out_max_y_reg;
    assign rect.last_of_run = out_last_reg;

    // No rectangle may be left waiting in the held stage between columns.
    `TCRM_ASSERT_IMP(a_idle_nothing_held, state_reg == S_IDLE, !held_valid_reg)
    // Every extraction step removes at least one row from the remaining mask.
    `TCRM_ASSERT_NEXT(a_rem_shrinks, step_go,
                      $countones(rem_reg) < $countones($past(rem_reg)))
    // Leaving the flush state returns to idle with the held stage drained.
    `TCRM_ASSERT_NEXT(a_flush_drains, (state_reg == S_FLUSH) && (!held_valid_reg || out_free),
                      (state_reg == S_IDLE) && !held_valid_reg)
    // Continued runs can only start on rows that were set in the previous column.
    `TCRM_ASSERT_IMP(a_matched_in_prev, state_reg != S_IDLE,
                     (matched_reg & ~prev_runs_reg) == '0)

endmodule

`default_nettype wire
